// ===== src/uer_pkg.sv =====
// Shared types, register codes, reset values and the distance conversion for the
// ultrasonic echo ranger. No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

   // measurement phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIG_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ECHO_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DIST     = 2'd2;

   localparam int TRIG_BITS      = 10;
   localparam int TIMEOUT_BITS   = 17;
   localparam int DIST_BITS      = 8;
   localparam int CSR_DATA_BITS  = 17;
   localparam int MAX_COUNT_BITS = 24;
   localparam int COUNT_BITS_DEF = 17;

   localparam logic [TRIG_BITS-1:0]    TRIG_TICKS_RESET   = 10'd10;
   localparam logic [TIMEOUT_BITS-1:0] ECHO_TIMEOUT_RESET = 17'd100000;
   localparam logic [DIST_BITS-1:0]    MAX_DIST_RESET     = 8'd40;

   // stream payload layout
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;

   // distance = floor(ticks * 343 / 20000); anything at or above DIST_SAT_TICKS
   // gives 256 or more and is clamped, below it a 14-bit tick count suffices
   localparam int SMALL_TICK_BITS = 14;
   localparam logic [MAX_COUNT_BITS-1:0] DIST_SAT_TICKS = 24'd14928;
   localparam int RECIP_BITS = 27;
   localparam int DIST_SHIFT = 32;
   localparam logic [RECIP_BITS-1:0] DIST_RECIP = 27'd73658690;
   localparam int PROD_BITS = SMALL_TICK_BITS + RECIP_BITS;

   function automatic logic [DIST_BITS-1:0] dist_calc(
      input logic [MAX_COUNT_BITS-1:0] ticks,
      input logic [DIST_BITS-1:0]      max_dist
   );
      logic [PROD_BITS-1:0] prod;
      logic [DIST_BITS-1:0] quot;
      prod = PROD_BITS'(ticks[SMALL_TICK_BITS-1:0]) * PROD_BITS'(DIST_RECIP);
      quot = prod[DIST_SHIFT +: DIST_BITS];
      if (ticks >= DIST_SAT_TICKS || quot > max_dist) begin
         dist_calc = max_dist;
      end else begin
         dist_calc = quot;
      end
   endfunction

endpackage

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: one request transfer per microsecond tick, one response per tick.
// Depends on uer_pkg for phase type, register codes, reset values and dist_calc.
`timescale 1ns / 1ps

// One request transfer is one microsecond tick carrying the start request and the sampled
// echo level; every request gives exactly one response, and a new request can be taken every
// cycle while the skid entry is empty. The phase, tick counter and distance update
// in a single pass of logic from the state registers into the response register; a response
// register plus one skid entry let one more request in while a response is stalled, after
// which req_tready drops until rsp_tready returns. The distance is computed by a constant
// multiply in that same pass when the echo falls. The tick counter is COUNT_BITS wide and
// saturates; configuration writes are always ready and take effect from the next tick.
module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [uer_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [0] start_request, [1] echo_level
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] trigger_out, [1] busy_res, [2] done_res, [3] timed_out, [11:4] distance_cm
   output logic [uer_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uer_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CMP_BITS = (COUNT_BITS > uer_pkg::TIMEOUT_BITS) ?
                             COUNT_BITS : uer_pkg::TIMEOUT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // configuration
   logic [uer_pkg::TRIG_BITS-1:0]    trig_ticks_ff;
   logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_ff;
   logic [uer_pkg::DIST_BITS-1:0]    max_dist_ff;

   // measurement state
   uer_pkg::phase_type               phase_ff, phase_in;
   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic [uer_pkg::DIST_BITS-1:0]    last_dist_ff, last_dist_in;

   // output register and skid entry
   logic                             rsp_valid_ff;
   logic [uer_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                             skid_valid_ff;
   logic [uer_pkg::RSP_DATA_BITS-1:0] skid_data_ff;

   logic                             req_accept;
   logic                             rsp_take;
   logic                             start_req;
   logic                             echo_lvl;
   logic [COUNT_BITS-1:0]            count_inc;
   logic                             count_at_max;
   logic                             trig_reached;
   logic                             timeout_reached;
   logic                             trig_first_done;
   logic [uer_pkg::DIST_BITS-1:0]    dist_now;
   logic                             trig_out;
   logic                             done_out;
   logic                             tout_out;
   logic [uer_pkg::RSP_DATA_BITS-1:0] result;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign start_req = req_tdata[0];
   assign echo_lvl  = req_tdata[1];

   assign count_at_max    = (count_ff == COUNT_MAX);
   assign count_inc       = count_at_max ? count_ff : count_ff + COUNT_ONE;
   assign trig_reached    = (CMP_BITS'(count_inc) >= CMP_BITS'(trig_ticks_ff)) ||
                            (count_inc == COUNT_MAX);
   assign timeout_reached = (CMP_BITS'(count_inc) >= CMP_BITS'(timeout_ff)) ||
                            (count_inc == COUNT_MAX);
   // a trigger length of zero or one ends the pulse on the start tick
   assign trig_first_done = (trig_ticks_ff <= uer_pkg::TRIG_BITS'(1));
   assign dist_now = uer_pkg::dist_calc(uer_pkg::MAX_COUNT_BITS'(count_ff), max_dist_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               phase_in = trig_first_done ? uer_pkg::PH_WAIT : uer_pkg::PH_TRIG;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (trig_reached) begin
               phase_in = uer_pkg::PH_WAIT;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo_lvl) begin
               phase_in = uer_pkg::PH_MEAS;
            end else if (timeout_reached) begin
               phase_in = uer_pkg::PH_IDLE;
            end
         end
         uer_pkg::PH_MEAS: begin
            if (!echo_lvl) begin
               phase_in = uer_pkg::PH_IDLE;
            end
         end
         default: phase_in = uer_pkg::PH_IDLE;
      endcase
   end

   // counter, distance and per-tick outputs
   always_comb begin
      count_in     = count_ff;
      last_dist_in = last_dist_ff;
      trig_out     = 1'b0;
      done_out     = 1'b0;
      tout_out     = 1'b0;
      case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               trig_out = 1'b1;
               count_in = trig_first_done ? '0 : COUNT_ONE;
            end
         end
         uer_pkg::PH_TRIG: begin
            trig_out = 1'b1;
            count_in = trig_reached ? '0 : count_inc;
         end
         uer_pkg::PH_WAIT: begin
            if (echo_lvl) begin
               count_in = COUNT_ONE;
            end else if (timeout_reached) begin
               count_in     = '0;
               last_dist_in = '0;
               done_out     = 1'b1;
               tout_out     = 1'b1;
            end else begin
               count_in = count_inc;
            end
         end
         uer_pkg::PH_MEAS: begin
            if (echo_lvl) begin
               count_in = count_inc;
            end else begin
               count_in     = '0;
               last_dist_in = dist_now;
               done_out     = 1'b1;
            end
         end
         default: count_in = '0;
      endcase
   end

   assign result = {4'b0000, last_dist_in, tout_out, done_out,
                    (phase_in != uer_pkg::PH_IDLE), trig_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff <= uer_pkg::TRIG_TICKS_RESET;
         timeout_ff    <= uer_pkg::ECHO_TIMEOUT_RESET;
         max_dist_ff   <= uer_pkg::MAX_DIST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uer_pkg::CSR_TRIG_TICKS:   trig_ticks_ff <= csr_data[uer_pkg::TRIG_BITS-1:0];
            uer_pkg::CSR_ECHO_TIMEOUT: timeout_ff    <= csr_data[uer_pkg::TIMEOUT_BITS-1:0];
            uer_pkg::CSR_MAX_DIST:     max_dist_ff   <= csr_data[uer_pkg::DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= uer_pkg::PH_IDLE;
         count_ff     <= '0;
         last_dist_ff <= '0;
      end else if (req_accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         last_dist_ff <= last_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_data_ff <= result;
         end else begin
            rsp_data_ff <= result;
         end
      end
   end

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == uer_pkg::PH_IDLE) |-> (count_ff == '0))
      else $error("tick counter not cleared in idle phase");

   a_timeout_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff[3] || rsp_data_ff[2]))
      else $error("timeout flag without done");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[2] && (rsp_data_ff[1] || rsp_data_ff[0])))
      else $error("done reported while busy or triggering");

   a_state_on_accept: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(phase_ff) && $stable(count_ff))
      else $error("measurement state moved without a request transfer");

endmodule
